// File: rtl/c_subset_lexer_defines.svh
// assertion macros used by the checker file
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CSLEX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CSLEX_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cslex_pkg.sv
package cslex_pkg;

    localparam int InDataBits  = 8;
    localparam int PosOutBits  = 16;
    localparam int ValOutBits  = 32;
    localparam int OutPayBits  = 2 * PosOutBits + ValOutBits + 1;
    localparam int OutDataBits = ((OutPayBits + 7) / 8) * 8;
    localparam int OutUserBits = 4;
    localparam int FifoDepth   = 8;
    localparam int FifoAw      = $clog2(FifoDepth);

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef enum logic [3:0] {
        KIND_INT, KIND_VOID, KIND_RETURN, KIND_IDENT, KIND_CONST,
        KIND_LPAREN, KIND_RPAREN, KIND_LBRACE, KIND_RBRACE, KIND_SEMI,
        KIND_COMMENT, KIND_END, KIND_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_IDENT, MODE_NUM, MODE_SLASH,
        MODE_LINE, MODE_BLOCK, MODE_BSTAR, MODE_SKIP
    } t_mode;

    typedef enum logic [1:0] {KW_NONE, KW_INT, KW_VOID, KW_RETURN} t_kw;

    typedef enum logic [2:0] {
        CLS_SPACE, CLS_ALPHA, CLS_DIGIT, CLS_PUNCT, CLS_SLASH, CLS_OTHER
    } t_cls;

    typedef struct packed {
        t_kind                 kind;
        logic [PosOutBits-1:0] start;
        logic [PosOutBits-1:0] len;
        logic [ValOutBits-1:0] value;
        logic                  sat;
        logic                  last;
    } t_token;

    function automatic t_cls char_class(input logic [7:0] c);
        t_cls cls;
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) cls = CLS_SPACE;
        else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F)
            cls = CLS_ALPHA;
        else if (c >= 8'h30 && c <= 8'h39) cls = CLS_DIGIT;
        else if (c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h7D || c == 8'h3B)
            cls = CLS_PUNCT;
        else if (c == CH_SLASH) cls = CLS_SLASH;
        else cls = CLS_OTHER;
        return cls;
    endfunction

    function automatic t_kind punct_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            default: k = KIND_SEMI;
        endcase
        return k;
    endfunction

    function automatic t_kw kw_first(input logic [7:0] c);
        t_kw k;
        case (c)
            8'h69:   k = KW_INT;
            8'h76:   k = KW_VOID;
            8'h72:   k = KW_RETURN;
            default: k = KW_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] kw_length(input t_kw k);
        logic [2:0] n;
        case (k)
            KW_INT:    n = 3'd3;
            KW_VOID:   n = 3'd4;
            KW_RETURN: n = 3'd6;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    // keyword spelling, first character in the top byte
    function automatic logic [7:0] kw_char(input t_kw k, input logic [2:0] idx);
        logic [47:0] txt;
        case (k)
            KW_INT:    txt = 48'h696E74000000;
            KW_VOID:   txt = 48'h766F69640000;
            KW_RETURN: txt = 48'h72657475726E;
            default:   txt = 48'h0;
        endcase
        if (idx > 3'd5) return 8'h00;
        return txt[8 * (5 - idx) +: 8];
    endfunction

    function automatic t_kind kw_token(input t_kw k);
        t_kind t;
        case (k)
            KW_INT:    t = KIND_INT;
            KW_VOID:   t = KIND_VOID;
            KW_RETURN: t = KIND_RETURN;
            default:   t = KIND_IDENT;
        endcase
        return t;
    endfunction

endpackage

// File: rtl/c_subset_lexer.sv
// channel  | dir | tdata                | tuser          | tlast
// s_axis   | in  | [7:0] char_byte      | -              | is_last
// m_axis   | out | start,len,value,sat  | [3:0] kind     | last token of the byte
//
// one source byte is taken per cycle and held in an input register while
// the scanner logic decides its tokens (0 to 3), which are written into an
// 8-entry token queue; the master side drains one token per cycle while
// m_axis_tready is high, so intake pauses only while the queue has fewer than
// three free slots; a token shows on m_axis after its write into the queue
// reset is synchronous, active low, and clears input valid, scanner and queue control only
// either side may stall at any time; a stalled output holds its token
module c_subset_lexer #(
    parameter int POSITION_BITS = 16,
    parameter int VALUE_BITS    = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [cslex_pkg::InDataBits-1:0]   i_s_axis_tdata,   // [7:0] char_byte
    input  logic                               i_s_axis_tlast,   // is_last
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [15:0] start_offset, [31:16] token_length, [63:32] const_value,
    // [64] value_saturated, rest zero
    output logic [cslex_pkg::OutDataBits-1:0]  o_m_axis_tdata,
    output logic [cslex_pkg::OutUserBits-1:0]  o_m_axis_tuser,   // [3:0] token_kind
    output logic                               o_m_axis_tlast    // last_of_run
);
    import cslex_pkg::*;

    localparam logic [POSITION_BITS-1:0] PosMax    = '1;
    localparam logic [VALUE_BITS-1:0]    ValMax    = '1;
    localparam logic [FifoAw:0]          FillLimit = (FifoAw + 1)'(FifoDepth - 3);

    // saturating position / length increment
    function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
        return (v == PosMax) ? v : v + 1'b1;
    endfunction

    function automatic logic [PosOutBits-1:0] pos_out(input logic [POSITION_BITS-1:0] v);
        logic [POSITION_BITS+PosOutBits-1:0] w;
        w = {{PosOutBits{1'b0}}, v};
        return w[PosOutBits-1:0];
    endfunction

    function automatic logic [ValOutBits-1:0] val_out(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS+ValOutBits-1:0] w;
        w = {{ValOutBits{1'b0}}, v};
        return w[ValOutBits-1:0];
    endfunction

    function automatic t_token make_tok(input t_kind kind,
                                        input logic [POSITION_BITS-1:0] start,
                                        input logic [POSITION_BITS-1:0] len);
        t_token t;
        t       = '0;
        t.kind  = kind;
        t.start = pos_out(start);
        t.len   = pos_out(len);
        return t;
    endfunction

    // identifier, keyword or constant token from a finished word
    function automatic t_token word_tok(input t_mode mode, input t_kw kw,
                                        input logic [POSITION_BITS-1:0] start,
                                        input logic [POSITION_BITS-1:0] len,
                                        input logic [VALUE_BITS-1:0] val,
                                        input logic ovf);
        t_token t;
        if (mode == MODE_IDENT) begin
            if (kw != KW_NONE && len == POSITION_BITS'(kw_length(kw)))
                t = make_tok(kw_token(kw), start, len);
            else
                t = make_tok(KIND_IDENT, start, len);
        end else begin
            t       = make_tok(KIND_CONST, start, len);
            t.value = val_out(val);
            t.sat   = ovf;
        end
        return t;
    endfunction

    // input register
    logic                     r_in_valid;
    logic [7:0]               r_in_byte;
    logic                     r_in_last;

    // scanner state
    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [POSITION_BITS-1:0] r_len, n_len;
    logic [POSITION_BITS-1:0] r_pos;
    t_kw                      r_kw, n_kw;
    logic [VALUE_BITS-1:0]    r_val, n_val;
    logic                     r_ovf, n_ovf;

    // token queue
    t_token                   r_fifo [FifoDepth];
    logic [FifoAw-1:0]        r_wr_ptr;
    logic [FifoAw-1:0]        r_rd_ptr;
    logic [FifoAw:0]          r_count;

    logic                     w_step;
    logic                     w_pop;
    t_cls                     w_class;
    logic [VALUE_BITS+3:0]    w_prod;
    logic                     w_kw_hit;
    logic                     w_brk;       // pending word closed by this byte
    logic                     w_beg;       // byte starts a new token
    logic                     w_num_err;   // digits run into a letter
    logic                     w_slash_err; // slash not opening a comment
    logic                     w_cmt;       // comment closed by this byte
    t_token                   w_tok [0:2];
    logic [1:0]               w_nres;
    t_token                   w_head;

    assign w_step          = r_in_valid && (r_count <= FillLimit);
    assign o_s_axis_tready = !r_in_valid || w_step;
    assign w_pop           = o_m_axis_tvalid && i_m_axis_tready;
    assign w_class         = char_class(r_in_byte);

    // value * 10 + digit, overflow shows in the top four bits
    assign w_prod = ({4'b0, r_val} << 3) + ({4'b0, r_val} << 1)
                  + {{VALUE_BITS{1'b0}}, r_in_byte[3:0]};

    assign w_kw_hit = (r_len < POSITION_BITS'(kw_length(r_kw)))
                   && (kw_char(r_kw, r_len[2:0]) == r_in_byte);

    // next state of the scanner for the byte in the input register
    always_comb begin
        n_mode      = r_mode;
        n_start     = r_start;
        n_len       = r_len;
        n_kw        = r_kw;
        n_val       = r_val;
        n_ovf       = r_ovf;
        w_brk       = 1'b0;
        w_beg       = 1'b0;
        w_num_err   = 1'b0;
        w_slash_err = 1'b0;
        w_cmt       = 1'b0;
        case (r_mode)
            MODE_IDLE: begin
                w_beg = 1'b1;
            end
            MODE_IDENT: begin
                if (w_class == CLS_ALPHA || w_class == CLS_DIGIT) begin
                    if (r_kw != KW_NONE && !w_kw_hit) n_kw = KW_NONE;
                    n_len = pos_inc(r_len);
                end else begin
                    w_brk  = 1'b1;
                    w_beg  = 1'b1;
                    n_mode = MODE_IDLE;
                end
            end
            MODE_NUM: begin
                if (w_class == CLS_DIGIT) begin
                    if (r_ovf || (|w_prod[VALUE_BITS+3:VALUE_BITS])) begin
                        n_val = ValMax;
                        n_ovf = 1'b1;
                    end else begin
                        n_val = w_prod[VALUE_BITS-1:0];
                    end
                    n_len = pos_inc(r_len);
                end else if (w_class == CLS_ALPHA) begin
                    w_num_err = 1'b1;
                    n_mode    = MODE_SKIP;
                end else begin
                    w_brk  = 1'b1;
                    w_beg  = 1'b1;
                    n_mode = MODE_IDLE;
                end
            end
            MODE_SLASH: begin
                n_len = pos_inc(r_len);
                if (r_in_byte == CH_SLASH) n_mode = MODE_LINE;
                else if (r_in_byte == CH_STAR) n_mode = MODE_BLOCK;
                else begin
                    w_slash_err = 1'b1;
                    n_mode      = MODE_SKIP;
                end
            end
            MODE_LINE: begin
                n_len = pos_inc(r_len);
                if (r_in_byte == CH_NL) begin
                    w_cmt  = 1'b1;
                    n_mode = MODE_IDLE;
                end
            end
            MODE_BLOCK: begin
                n_len = pos_inc(r_len);
                if (r_in_byte == CH_STAR) n_mode = MODE_BSTAR;
            end
            MODE_BSTAR: begin
                n_len = pos_inc(r_len);
                if (r_in_byte == CH_SLASH) begin
                    w_cmt  = 1'b1;
                    n_mode = MODE_IDLE;
                end else if (r_in_byte != CH_STAR) begin
                    n_mode = MODE_BLOCK;
                end
            end
            default: ;  // error skip until the last byte
        endcase

        if (w_beg && w_class != CLS_SPACE) begin
            n_start = r_pos;
            n_len   = POSITION_BITS'(1);
            case (w_class)
                CLS_ALPHA: begin
                    n_mode = MODE_IDENT;
                    n_kw   = kw_first(r_in_byte);
                end
                CLS_DIGIT: begin
                    n_mode = MODE_NUM;
                    n_val  = {{(VALUE_BITS-4){1'b0}}, r_in_byte[3:0]};
                    n_ovf  = 1'b0;
                end
                CLS_PUNCT: ;
                CLS_SLASH: n_mode = MODE_SLASH;
                default:   n_mode = MODE_SKIP;
            endcase
        end
    end

    // tokens for the byte in the input register, in emission order
    always_comb begin
        logic [1:0] k;
        k        = 2'd0;
        w_tok[0] = '0;
        w_tok[1] = '0;
        w_tok[2] = '0;
        if (w_brk) begin
            w_tok[k] = word_tok(r_mode, r_kw, r_start, r_len, r_val, r_ovf);
            k        = k + 2'd1;
        end
        if (w_beg && w_class == CLS_PUNCT) begin
            w_tok[k] = make_tok(punct_kind(r_in_byte), r_pos, POSITION_BITS'(1));
            k        = k + 2'd1;
        end
        if (w_beg && w_class == CLS_OTHER) begin
            w_tok[k] = make_tok(KIND_ERROR, r_pos, POSITION_BITS'(1));
            k        = k + 2'd1;
        end
        if (w_num_err) begin
            w_tok[k] = make_tok(KIND_ERROR, r_start, pos_inc(r_len));
            k        = k + 2'd1;
        end
        if (w_slash_err) begin
            w_tok[k] = make_tok(KIND_ERROR, r_start, POSITION_BITS'(1));
            k        = k + 2'd1;
        end
        if (w_cmt) begin
            w_tok[k] = make_tok(KIND_COMMENT, r_start, n_len);
            k        = k + 2'd1;
        end
        if (r_in_last) begin
            // flush an open word, flag an open comment or slash, then end
            if (n_mode == MODE_IDENT || n_mode == MODE_NUM) begin
                w_tok[k] = word_tok(n_mode, n_kw, n_start, n_len, n_val, n_ovf);
                k        = k + 2'd1;
            end else if (n_mode == MODE_SLASH || n_mode == MODE_LINE ||
                         n_mode == MODE_BLOCK || n_mode == MODE_BSTAR) begin
                w_tok[k] = make_tok(KIND_ERROR, n_start, n_len);
                k        = k + 2'd1;
            end
            w_tok[k] = make_tok(KIND_END, pos_inc(r_pos), '0);
            k        = k + 2'd1;
        end
        if (k != 2'd0) w_tok[k - 2'd1].last = 1'b1;
        w_nres = k;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata[7:0];
            r_in_last <= i_s_axis_tlast;
        end
    end

    // scanner state, back to reset values after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_len   <= '0;
            r_pos   <= '0;
            r_kw    <= KW_NONE;
            r_val   <= '0;
            r_ovf   <= 1'b0;
        end else if (w_step) begin
            if (r_in_last) begin
                r_mode  <= MODE_IDLE;
                r_start <= '0;
                r_len   <= '0;
                r_pos   <= '0;
                r_kw    <= KW_NONE;
                r_val   <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_mode  <= n_mode;
                r_start <= n_start;
                r_len   <= n_len;
                r_pos   <= pos_inc(r_pos);
                r_kw    <= n_kw;
                r_val   <= n_val;
                r_ovf   <= n_ovf;
            end
        end
    end

    // token queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_step) r_wr_ptr <= r_wr_ptr + FifoAw'(w_nres);
            if (w_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (w_step ? (FifoAw + 1)'(w_nres) : '0)
                     - (FifoAw + 1)'(w_pop);
        end
    end

    // token queue storage, up to three writes per byte
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            for (int i = 0; i < 3; i++) begin
                if (i < w_nres) r_fifo[r_wr_ptr + FifoAw'(i)] <= w_tok[i];
            end
        end
    end

    assign w_head          = r_fifo[r_rd_ptr];
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {{(OutDataBits - OutPayBits){1'b0}},
                              w_head.sat, w_head.value, w_head.len, w_head.start};
    assign o_m_axis_tuser  = w_head.kind;
    assign o_m_axis_tlast  = w_head.last;

endmodule

// File: rtl/cslex_checker.sv
`include "c_subset_lexer_defines.svh"

module cslex_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [cslex_pkg::OutDataBits-1:0] o_m_axis_tdata,
    input logic [cslex_pkg::OutUserBits-1:0] o_m_axis_tuser,
    input logic                              o_m_axis_tlast
);
    import cslex_pkg::*;

    logic [PosOutBits-1:0] w_len;
    logic                  w_in_req;

    assign w_len    = o_m_axis_tdata[2*PosOutBits-1:PosOutBits];
    assign w_in_req = i_s_axis_tvalid && o_s_axis_tready;

    // a stalled token holds
    `CSLEX_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast), "token changed while stalled")

    // the end token closes its byte and has no length
    `CSLEX_ASSERT_IMP(a_end_shape, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser == KIND_END, o_m_axis_tlast && w_len == '0, "malformed end token")

    // a return keyword is exactly six bytes long
    `CSLEX_ASSERT_IMP(a_return_len, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser == KIND_RETURN, w_len == PosOutBits'(6), "return keyword with wrong length")

    // no token appears the cycle after the first input request out of reset
    `CSLEX_ASSERT_NXT(a_no_early_token, i_clk, i_rst_n, !$past(i_rst_n) && w_in_req && !o_m_axis_tvalid, !o_m_axis_tvalid, "token ahead of the scanner")

endmodule

bind c_subset_lexer cslex_checker u_cslex_checker (.*);
